// ===== design/ogt_pkg.sv =====
// Package for the outer-product tile accumulator: shared types, codes and constants.
// No dependencies; every other design file imports it.
`timescale 1ns / 1ps

package ogt_pkg;

    localparam int LANES  = 4;
    localparam int QDEPTH = 2;

    localparam logic [63:0] DEFAULT_NAN = 64'h7FF8000000000000;
    localparam logic [63:0] ONE_BITS    = 64'h3FF0000000000000;

    // register select taken from paddr[3]
    localparam logic REG_ALPHA = 1'b0;
    localparam logic REG_GAMMA = 1'b1;

    typedef logic [63:0] fp_t;

    typedef struct packed {
        fp_t [LANES-1:0] a;
        fp_t [LANES-1:0] b;
        logic            first;
        logic            last;
        logic            scale;
    } slice_t;

    typedef enum logic [0:0] {
        FOP_MUL,
        FOP_ADD
    } fop_t;

    typedef struct packed {
        logic start;
        fop_t op;
        fp_t  x;
        fp_t  y;
    } fpu_req_t;

    typedef struct packed {
        logic done;
        fp_t  result;
    } fpu_rsp_t;

    typedef enum logic [2:0] {
        FPU_IDLE,
        FPU_MUL,
        FPU_ALIGN,
        FPU_SUM,
        FPU_NORM,
        FPU_ROUND
    } fpu_state_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_MUL,
        SEQ_ACC,
        SEQ_ROW,
        SEQ_SMUL,
        SEQ_SADD,
        SEQ_OUT
    } seq_state_t;

endpackage

// ===== design/outer_product_gemm_tile.sv =====
// Top level of the fp64 outer-product tile accumulator with its APB register port.
// Depends on ogt_pkg, ogt_front, ogt_fpu and ogt_back.
`timescale 1ns / 1ps

// Each accepted transaction carries one k-slice (a column of A, a row of B) that is
// added as an outer product into a resident TILE_ROWS x TILE_COLS binary64 tile;
// first_step starts from a zero tile, last_step emits the tile one row per output
// transaction, row 0 first, optionally as alpha*acc+gamma (alpha_scale at byte 0,
// gamma_offset at byte 8, written over APB while the block is idle). A two-entry
// queue takes new slices while the back end works. All arithmetic runs through
// one shared iterative fp64 unit: a multiply forms four 27x27 partial products,
// then normalizes and rounds, and an add aligns, sums, normalizes and rounds.
// Normalization takes longer when subnormals need it. Emission passes each row
// out raw, or with scaling runs one multiply and one add per element.
module outer_product_gemm_tile
    import ogt_pkg::*;
#(
    parameter int TILE_ROWS = 4,
    parameter int TILE_COLS = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] a_elem0,
    input  logic [63:0] a_elem1,
    input  logic [63:0] a_elem2,
    input  logic [63:0] a_elem3,
    input  logic [63:0] b_elem0,
    input  logic [63:0] b_elem1,
    input  logic [63:0] b_elem2,
    input  logic [63:0] b_elem3,
    input  logic        first_step,
    input  logic        last_step,
    input  logic        apply_scale,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] c_elem0,
    output logic [63:0] c_elem1,
    output logic [63:0] c_elem2,
    output logic [63:0] c_elem3,
    output logic [1:0]  row_index,
    output logic        last_row
);

    fp_t             alpha_reg, gamma_reg;
    slice_t          in_slice, head;
    logic            head_valid, pop;
    fpu_req_t        req;
    fpu_rsp_t        rsp;
    fp_t [LANES-1:0] c_row;

    assign pready = 1'b1;
    assign prdata = (paddr[3] == REG_GAMMA) ? gamma_reg : alpha_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= ONE_BITS;
            gamma_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[3] == REG_ALPHA)
                alpha_reg <= pwdata;
            else
                gamma_reg <= pwdata;
        end
    end

    always_comb
    begin
        in_slice.a[0]  = a_elem0;
        in_slice.a[1]  = a_elem1;
        in_slice.a[2]  = a_elem2;
        in_slice.a[3]  = a_elem3;
        in_slice.b[0]  = b_elem0;
        in_slice.b[1]  = b_elem1;
        in_slice.b[2]  = b_elem2;
        in_slice.b[3]  = b_elem3;
        in_slice.first = first_step;
        in_slice.last  = last_step;
        in_slice.scale = apply_scale;
    end

    ogt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_slice   (in_slice),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop)
    );

    ogt_fpu u_fpu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    ogt_back #(
        .TILE_ROWS (TILE_ROWS),
        .TILE_COLS (TILE_COLS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .alpha      (alpha_reg),
        .gamma      (gamma_reg),
        .req        (req),
        .rsp        (rsp),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .c_row      (c_row),
        .row_index  (row_index),
        .last_row   (last_row)
    );

    assign c_elem0 = c_row[0];
    assign c_elem1 = c_row[1];
    assign c_elem2 = c_row[2];
    assign c_elem3 = c_row[3];

endmodule

// ===== design/ogt_front.sv =====
// Front end: accepts k-slice transactions and queues them for the back end.
// Depends on ogt_pkg.
`timescale 1ns / 1ps

module ogt_front
    import ogt_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  slice_t in_slice,
    output slice_t head,
    output logic   head_valid,
    input  logic   pop
);

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    slice_t            mem_reg [QDEPTH];
    logic [PTR_W-1:0]  wptr_reg, rptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              push;
    slice_t            entry;

    assign in_ready   = (count_reg != CNT_W'(QDEPTH));
    assign push       = in_valid && in_ready;
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rptr_reg];

    // scaling only matters on the closing slice of a run
    always_comb
    begin
        entry       = in_slice;
        entry.scale = in_slice.scale & in_slice.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= (wptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            if (pop)
                rptr_reg <= (rptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= entry;
    end

`ifndef SYNTHESIS
    a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> head_valid)
        else $error("queue empty right after a push");
`endif

endmodule

// ===== design/ogt_fpu.sv =====
// Shared iterative binary64 unit: multiply or add, round to nearest even.
// Depends on ogt_pkg.
`timescale 1ns / 1ps

module ogt_fpu
    import ogt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  fpu_req_t req,
    output fpu_rsp_t rsp
);

    fpu_state_t         state_reg, state_next;
    logic               sign_reg, sign_next;
    logic               sub_reg, sub_next;
    logic signed [12:0] exp_reg, exp_next;
    logic [105:0]       norm_reg, norm_next;
    logic [63:0]        big_reg, big_next;
    logic [63:0]        small_reg, small_next;
    logic [52:0]        ma_reg, ma_next, mb_reg, mb_next;
    logic [1:0]         cnt_reg, cnt_next;
    fp_t                res_reg, res_next;
    logic               done_reg, done_next;

    function automatic logic [10:0] eff_exp(input logic [10:0] e);
        return (e == 11'd0) ? 11'd1 : e;
    endfunction

    function automatic logic [52:0] sig53(input logic [62:0] v);
        return {v[62:52] != 11'd0, v[51:0]};
    endfunction

    // m holds the significand with its leading one at bit 63; e is the biased
    // exponent of that bit. Denormalize when e drops below one.
    function automatic fp_t fp_round(input logic s, input logic signed [12:0] e,
                                     input logic [63:0] m, input logic st);
        logic [12:0]        sh;
        logic [63:0]        m2;
        logic               st2;
        logic [52:0]        mant;
        logic               inc;
        logic [53:0]        mr;
        logic signed [12:0] ee;
        fp_t                r;
        if (e >= 13'sd1)
        begin
            sh  = '0;
            m2  = m;
            st2 = st;
        end
        else
        begin
            sh  = 13'(13'sd1 - e);
            m2  = m >> sh;
            st2 = st | (|(m & ~({64{1'b1}} << sh)));
        end
        mant = m2[63:11];
        inc  = m2[10] & (st2 | (|m2[9:0]) | mant[0]);
        mr   = {1'b0, mant} + 54'(inc);
        if (e >= 13'sd1)
        begin
            ee = mr[53] ? e + 13'sd1 : e;
            if (ee >= 13'sd2047)
                r = {s, 11'h7FF, 52'd0};
            else
                r = {s, ee[10:0], mr[53] ? mr[52:1] : mr[51:0]};
        end
        else
        begin
            ee = '0;
            r  = {s, 10'd0, mr[52], mr[51:0]};
        end
        if (sh == 13'h1FFF && ee == 13'sd1)
            r = DEFAULT_NAN;
        return r;
    endfunction

    logic        x_s, y_s, x_nan, y_nan, x_inf, y_inf, x_zero, y_zero;
    logic        mul_nan, add_nan, swap;
    logic [10:0] eb, es, exp_gap;
    logic [52:0] mbig, msmall;
    logic [63:0] sm_full;
    logic [63:0] sum;
    logic [26:0] opa, opb;
    logic [53:0] pp;
    logic [6:0]  pp_sh;

    always_comb
    begin
        x_s     = req.x[63];
        y_s     = req.y[63];
        x_nan   = (req.x[62:52] == 11'h7FF) && (req.x[51:0] != '0);
        y_nan   = (req.y[62:52] == 11'h7FF) && (req.y[51:0] != '0);
        x_inf   = (req.x[62:52] == 11'h7FF) && (req.x[51:0] == '0);
        y_inf   = (req.y[62:52] == 11'h7FF) && (req.y[51:0] == '0);
        x_zero  = (req.x[62:0] == '0);
        y_zero  = (req.y[62:0] == '0);
        mul_nan = x_nan || y_nan || (x_inf && y_zero) || (x_zero && y_inf);
        add_nan = x_nan || y_nan || (x_inf && y_inf && (x_s != y_s));
        swap    = req.y[62:0] > req.x[62:0];

        eb      = eff_exp(big_reg[62:52]);
        es      = eff_exp(small_reg[62:52]);
        exp_gap = eb - es;
        mbig    = sig53(big_reg[62:0]);
        msmall  = sig53(small_reg[62:0]);
        sm_full = {1'b0, msmall, 10'd0};
        sum     = sub_reg ? big_reg - small_reg : big_reg + small_reg;

        opa     = cnt_reg[1] ? {1'b0, ma_reg[52:27]} : ma_reg[26:0];
        opb     = cnt_reg[0] ? {1'b0, mb_reg[52:27]} : mb_reg[26:0];
        pp      = opa * opb;
        pp_sh   = (cnt_reg[1] ? 7'd27 : 7'd0) + (cnt_reg[0] ? 7'd27 : 7'd0);
    end

    always_comb
    begin
        state_next = state_reg;
        sign_next  = sign_reg;
        sub_next   = sub_reg;
        exp_next   = exp_reg;
        norm_next  = norm_reg;
        big_next   = big_reg;
        small_next = small_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        cnt_next   = cnt_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            FPU_IDLE:
            begin
                if (req.start)
                begin
                    if (req.op == FOP_MUL)
                    begin
                        sign_next = x_s ^ y_s;
                        if (mul_nan)
                        begin
                            res_next  = DEFAULT_NAN;
                            done_next = 1'b1;
                        end
                        else if (x_inf || y_inf)
                        begin
                            res_next  = {x_s ^ y_s, 11'h7FF, 52'd0};
                            done_next = 1'b1;
                        end
                        else if (x_zero || y_zero)
                        begin
                            res_next  = {x_s ^ y_s, 63'd0};
                            done_next = 1'b1;
                        end
                        else
                        begin
                            ma_next    = sig53(req.x[62:0]);
                            mb_next    = sig53(req.y[62:0]);
                            norm_next  = '0;
                            exp_next   = $signed(13'({2'b00, eff_exp(req.x[62:52])})
                                       + 13'({2'b00, eff_exp(req.y[62:52])}) - 13'd1022);
                            cnt_next   = '0;
                            state_next = FPU_MUL;
                        end
                    end
                    else
                    begin
                        if (add_nan)
                        begin
                            res_next  = DEFAULT_NAN;
                            done_next = 1'b1;
                        end
                        else if (x_inf)
                        begin
                            res_next  = req.x;
                            done_next = 1'b1;
                        end
                        else if (y_inf)
                        begin
                            res_next  = req.y;
                            done_next = 1'b1;
                        end
                        else if (x_zero && y_zero)
                        begin
                            res_next  = {x_s & y_s, 63'd0};
                            done_next = 1'b1;
                        end
                        else
                        begin
                            big_next   = swap ? req.y : req.x;
                            small_next = swap ? req.x : req.y;
                            state_next = FPU_ALIGN;
                        end
                    end
                end
            end
            FPU_MUL:
            begin
                norm_next = norm_reg + (106'(pp) << pp_sh);
                cnt_next  = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                    state_next = FPU_NORM;
            end
            FPU_ALIGN:
            begin
                // fold the shifted-out bits into a sticky lsb
                sign_next  = big_reg[63];
                sub_next   = big_reg[63] ^ small_reg[63];
                exp_next   = $signed(13'({2'b00, eb}) + 13'd1);
                big_next   = {1'b0, mbig, 10'd0};
                small_next = (sm_full >> exp_gap)
                           | 64'(|(sm_full & ~({64{1'b1}} << exp_gap)));
                state_next = FPU_SUM;
            end
            FPU_SUM:
            begin
                if (sum == '0)
                begin
                    res_next   = '0;
                    done_next  = 1'b1;
                    state_next = FPU_IDLE;
                end
                else
                begin
                    norm_next  = {sum, 42'd0};
                    state_next = FPU_NORM;
                end
            end
            FPU_NORM:
            begin
                if (norm_reg[105])
                    state_next = FPU_ROUND;
                else if (norm_reg[105:98] == '0)
                begin
                    norm_next = norm_reg << 8;
                    exp_next  = exp_reg - 13'sd8;
                end
                else
                begin
                    norm_next = norm_reg << 1;
                    exp_next  = exp_reg - 13'sd1;
                end
            end
            FPU_ROUND:
            begin
                res_next   = fp_round(sign_reg, exp_reg, norm_reg[105:42], |norm_reg[41:0]);
                done_next  = 1'b1;
                state_next = FPU_IDLE;
            end
            default:
            begin
                state_next = FPU_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FPU_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sign_reg  <= sign_next;
        sub_reg   <= sub_next;
        exp_reg   <= exp_next;
        norm_reg  <= norm_next;
        big_reg   <= big_next;
        small_reg <= small_next;
        ma_reg    <= ma_next;
        mb_reg    <= mb_next;
        cnt_reg   <= cnt_next;
        res_reg   <= res_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> (state_reg == FPU_IDLE) && !done_reg)
        else $error("operation issued while the unit is busy");
`endif

endmodule

// ===== design/ogt_back.sv =====
// Back end: sequences tile updates and row emission through the shared fp64 unit.
// Depends on ogt_pkg; drives ogt_fpu through a request/response struct pair.
`timescale 1ns / 1ps

module ogt_back
    import ogt_pkg::*;
#(
    parameter int TILE_ROWS = 4,
    parameter int TILE_COLS = 4
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  slice_t          head,
    input  logic            head_valid,
    output logic            pop,
    input  fp_t             alpha,
    input  fp_t             gamma,
    output fpu_req_t        req,
    input  fpu_rsp_t        rsp,
    output logic            out_valid,
    input  logic            out_ready,
    output fp_t [LANES-1:0] c_row,
    output logic [1:0]      row_index,
    output logic            last_row
);

    seq_state_t  state_reg, state_next;
    logic [1:0]  r_reg, r_next, c_reg, c_next;
    logic        pend_reg, pend_next;
    fp_t         prod_reg, prod_next;
    fp_t         acc_reg [LANES*LANES];
    fp_t         row_reg [LANES];
    logic        acc_we, row_we;
    fp_t         row_wdata;
    logic [3:0]  idx;
    logic        last_c, last_r, col_used;

    assign idx      = {r_reg, c_reg};
    assign last_c   = (c_reg == 2'(TILE_COLS - 1));
    assign last_r   = (r_reg == 2'(TILE_ROWS - 1));
    assign col_used = ({1'b0, c_reg} < 3'(TILE_COLS));

    always_comb
    begin
        state_next = state_reg;
        r_next     = r_reg;
        c_next     = c_reg;
        pend_next  = pend_reg;
        prod_next  = prod_reg;
        acc_we     = 1'b0;
        row_we     = 1'b0;
        row_wdata  = '0;
        pop        = 1'b0;
        out_valid  = 1'b0;
        req.start  = 1'b0;
        req.op     = FOP_MUL;
        req.x      = '0;
        req.y      = '0;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                r_next = '0;
                c_next = '0;
                if (head_valid)
                    state_next = SEQ_MUL;
            end
            SEQ_MUL:
            begin
                req.op    = FOP_MUL;
                req.x     = head.a[r_reg];
                req.y     = head.b[c_reg];
                req.start = !pend_reg;
                pend_next = 1'b1;
                if (rsp.done)
                begin
                    pend_next  = 1'b0;
                    prod_next  = rsp.result;
                    state_next = SEQ_ACC;
                end
            end
            SEQ_ACC:
            begin
                // a first slice adds onto a cleared tile
                req.op    = FOP_ADD;
                req.x     = head.first ? '0 : acc_reg[idx];
                req.y     = prod_reg;
                req.start = !pend_reg;
                pend_next = 1'b1;
                if (rsp.done)
                begin
                    pend_next = 1'b0;
                    acc_we    = 1'b1;
                    if (!last_c)
                    begin
                        c_next     = c_reg + 2'd1;
                        state_next = SEQ_MUL;
                    end
                    else
                    begin
                        c_next = '0;
                        if (!last_r)
                        begin
                            r_next     = r_reg + 2'd1;
                            state_next = SEQ_MUL;
                        end
                        else if (head.last)
                        begin
                            r_next     = '0;
                            state_next = SEQ_ROW;
                        end
                        else
                        begin
                            pop        = 1'b1;
                            state_next = SEQ_IDLE;
                        end
                    end
                end
            end
            SEQ_ROW:
            begin
                if (col_used && head.scale)
                    state_next = SEQ_SMUL;
                else
                begin
                    row_we    = 1'b1;
                    row_wdata = col_used ? acc_reg[idx] : '0;
                    c_next    = c_reg + 2'd1;
                    if (c_reg == 2'(LANES - 1))
                        state_next = SEQ_OUT;
                end
            end
            SEQ_SMUL:
            begin
                req.op    = FOP_MUL;
                req.x     = acc_reg[idx];
                req.y     = alpha;
                req.start = !pend_reg;
                pend_next = 1'b1;
                if (rsp.done)
                begin
                    pend_next  = 1'b0;
                    prod_next  = rsp.result;
                    state_next = SEQ_SADD;
                end
            end
            SEQ_SADD:
            begin
                req.op    = FOP_ADD;
                req.x     = prod_reg;
                req.y     = gamma;
                req.start = !pend_reg;
                pend_next = 1'b1;
                if (rsp.done)
                begin
                    pend_next  = 1'b0;
                    row_we     = 1'b1;
                    row_wdata  = rsp.result;
                    c_next     = c_reg + 2'd1;
                    state_next = (c_reg == 2'(LANES - 1)) ? SEQ_OUT : SEQ_ROW;
                end
            end
            SEQ_OUT:
            begin
                out_valid = 1'b1;
                c_next    = '0;
                if (out_ready)
                begin
                    if (last_r)
                    begin
                        pop        = 1'b1;
                        state_next = SEQ_IDLE;
                    end
                    else
                    begin
                        r_next     = r_reg + 2'd1;
                        state_next = SEQ_ROW;
                    end
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
            r_reg     <= '0;
            c_reg     <= '0;
            pend_reg  <= 1'b0;
            for (int i = 0; i < LANES*LANES; i++)
                acc_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            r_reg     <= r_next;
            c_reg     <= c_next;
            pend_reg  <= pend_next;
            if (acc_we)
                acc_reg[idx] <= rsp.result;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (row_we)
            row_reg[c_reg] <= row_wdata;
    end

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
            c_row[i] = row_reg[i];
    end

    assign row_index = r_reg;
    assign last_row  = last_r;

`ifndef SYNTHESIS
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue popped while empty");
    a_out_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> head_valid && head.last)
        else $error("row emitted for a slice that does not close a run");
`endif

endmodule
